// ===== hdl/pts_pkg.sv =====
package pts_pkg;

    localparam int MAX_ENTRIES_DEF = 8;
    localparam int COUNT_OUT_W = 4;
    localparam logic [31:0] NO_SLEEP = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_TICK    = 3'd2,
        CMD_RESCHED = 3'd3,
        CMD_COMMIT  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        TS_READY    = 2'd0,
        TS_RUNNING  = 2'd1,
        TS_SLEEPING = 2'd2,
        TS_BLOCKED  = 2'd3
    } tstate_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        tstate_t     state;
        logic [31:0] sleep;
    } entry_t;

    typedef enum logic [1:0] {
        TBL_HOLD,
        TBL_INSERT,
        TBL_ROTATE,
        TBL_DELETE
    } tbl_op_t;

    typedef struct packed {
        tbl_op_t op;
        entry_t  ins;
        entry_t  upd;
    } tbl_ctrl_t;

    typedef struct packed {
        entry_t upd;
        logic   take;
        logic   lower;
        logic   match;
    } step_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_DELETE,
        S_WALK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [7:0]             next_id;
        logic                   next_valid;
        logic                   switch_needed;
        logic [7:0]             current_id;
        logic [31:0]            min_sleep_count;
        logic [63:0]            clock_ticks;
        logic                   table_full;
        logic [COUNT_OUT_W-1:0] entry_count;
    } result_t;

endpackage

// ===== hdl/pts_in_if.sv =====
interface pts_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [7:0]  thread_id;
    logic [7:0]  priority_req;
    logic [1:0]  thread_state;
    logic [31:0] sleep_count;

    modport source (
        output valid, command, thread_id, priority_req, thread_state, sleep_count,
        input  ready
    );

    modport sink (
        input  valid, command, thread_id, priority_req, thread_state, sleep_count,
        output ready
    );
endinterface

// ===== hdl/pts_out_if.sv =====
interface pts_out_if;
    logic                            valid;
    logic                            ready;
    logic [7:0]                      next_id;
    logic                            next_valid;
    logic                            switch_needed;
    logic [7:0]                      current_id;
    logic [31:0]                     min_sleep_count;
    logic [63:0]                     clock_ticks;
    logic                            table_full;
    logic [pts_pkg::COUNT_OUT_W-1:0] entry_count;

    modport source (
        output valid, next_id, next_valid, switch_needed, current_id,
               min_sleep_count, clock_ticks, table_full, entry_count,
        input  ready
    );

    modport sink (
        input  valid, next_id, next_valid, switch_needed, current_id,
               min_sleep_count, clock_ticks, table_full, entry_count,
        output ready
    );
endinterface

// ===== hdl/pts_step_unit.sv =====
module pts_step_unit (
    input  pts_pkg::entry_t    head,
    input  logic               in_range,
    input  logic               do_tick,
    input  logic               found,
    input  logic [7:0]         best,
    input  logic [31:0]        min_val,
    input  logic [7:0]         match_id,
    output pts_pkg::step_out_t result
);

    pts_pkg::entry_t upd;

    always_comb
    begin
        upd = head;
        // countdown and wake of a sleeping entry on tick
        if (do_tick && in_range && head.state == pts_pkg::TS_SLEEPING)
        begin
            if (head.sleep != 32'd0)
            begin
                upd.sleep = head.sleep - 32'd1;
            end
            if (upd.sleep == 32'd0)
            begin
                upd.state = pts_pkg::TS_READY;
            end
        end
    end

    always_comb
    begin
        result.upd   = upd;
        // >= so that a later entry wins a tie
        result.take  = in_range
                       && (upd.state == pts_pkg::TS_READY || upd.state == pts_pkg::TS_RUNNING)
                       && (!found || upd.prio >= best);
        result.lower = in_range && upd.state == pts_pkg::TS_SLEEPING && upd.sleep < min_val;
        result.match = in_range && head.id == match_id;
    end

endmodule

// ===== hdl/pts_table.sv =====
module pts_table #(
    parameter int MAX_ENTRIES = pts_pkg::MAX_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pts_pkg::tbl_ctrl_t             ctrl,
    input  logic [$clog2(MAX_ENTRIES)-1:0] del_idx,
    output pts_pkg::entry_t                head
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);

    pts_pkg::entry_t slot_reg  [MAX_ENTRIES];
    pts_pkg::entry_t slot_next [MAX_ENTRIES];

    always_comb
    begin
        for (int j = 0; j < MAX_ENTRIES; j++)
        begin
            slot_next[j] = slot_reg[j];
        end
        case (ctrl.op)
            pts_pkg::TBL_INSERT:
            begin
                slot_next[0] = ctrl.ins;
                for (int j = 1; j < MAX_ENTRIES; j++)
                begin
                    slot_next[j] = slot_reg[j-1];
                end
            end
            pts_pkg::TBL_ROTATE:
            begin
                // the step unit sees slot 0; its updated copy goes in at the back
                for (int j = 0; j < MAX_ENTRIES - 1; j++)
                begin
                    slot_next[j] = slot_reg[j+1];
                end
                slot_next[MAX_ENTRIES-1] = ctrl.upd;
            end
            pts_pkg::TBL_DELETE:
            begin
                for (int j = 0; j < MAX_ENTRIES - 1; j++)
                begin
                    if (IDX_W'(j) >= del_idx)
                    begin
                        slot_next[j] = slot_reg[j+1];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // all zero is the idle thread in slot 0
            for (int j = 0; j < MAX_ENTRIES; j++)
            begin
                slot_reg[j] <= '0;
            end
        end
        else
        begin
            for (int j = 0; j < MAX_ENTRIES; j++)
            begin
                slot_reg[j] <= slot_next[j];
            end
        end
    end

    assign head = slot_reg[0];

endmodule

// ===== hdl/pts_ctrl.sv =====
module pts_ctrl #(
    parameter int MAX_ENTRIES = pts_pkg::MAX_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     command,
    input  logic [7:0]                     thread_id,
    input  logic [7:0]                     priority_req,
    input  logic [1:0]                     thread_state,
    input  logic [31:0]                    sleep_count,
    output logic                           res_valid,
    input  logic                           res_ready,
    output pts_pkg::result_t               res,
    input  pts_pkg::entry_t                head,
    output pts_pkg::tbl_ctrl_t             tbl,
    output logic [$clog2(MAX_ENTRIES)-1:0] del_idx
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ENTRIES);

    pts_pkg::state_t state_reg, state_next;
    logic [2:0]       cmd_reg, cmd_next;
    logic [7:0]       id_reg, id_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic             found_reg, found_next;
    logic [7:0]       best_reg, best_next;
    logic [7:0]       pick_reg, pick_next;
    logic [31:0]      acc_min_reg, acc_min_next;
    logic             del_found_reg, del_found_next;
    logic [IDX_W-1:0] del_idx_reg, del_idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       current_reg, current_next;
    logic [7:0]       chosen_id_reg, chosen_id_next;
    logic             chosen_valid_reg, chosen_valid_next;
    logic [31:0]      min_sleep_reg, min_sleep_next;
    logic [63:0]      clock_reg, clock_next;
    logic             refused_reg, refused_next;
    logic             res_valid_reg, res_valid_next;
    pts_pkg::result_t res_reg, res_next;

    logic                                    accept;
    logic                                    full;
    logic                                    in_range;
    logic                                    last;
    logic                                    walk_tick;
    logic                                    pick_cmd;
    logic                                    out_free;
    logic [CNT_W+pts_pkg::COUNT_OUT_W-1:0]   count_ext;
    pts_pkg::step_out_t                      sout;

    assign accept    = in_valid && state_reg == pts_pkg::S_IDLE;
    assign full      = count_reg == FULL_COUNT;
    assign in_range  = CNT_W'(step_reg) < count_reg;
    assign last      = step_reg == LAST_STEP;
    assign pick_cmd  = cmd_reg == pts_pkg::CMD_TICK || cmd_reg == pts_pkg::CMD_RESCHED;
    assign walk_tick = state_reg == pts_pkg::S_WALK && cmd_reg == pts_pkg::CMD_TICK;
    assign out_free  = !res_valid_reg || res_ready;
    assign count_ext = {{pts_pkg::COUNT_OUT_W{1'b0}}, count_reg};

    pts_step_unit u_step (
        .head     (head),
        .in_range (in_range),
        .do_tick  (walk_tick),
        .found    (found_reg),
        .best     (best_reg),
        .min_val  (acc_min_reg),
        .match_id (id_reg),
        .result   (sout)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pts_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (pts_pkg::cmd_t'(command)) inside
                        pts_pkg::CMD_ADD:
                        begin
                            state_next = full ? pts_pkg::S_FINISH : pts_pkg::S_WALK;
                        end
                        pts_pkg::CMD_REMOVE:
                        begin
                            state_next = pts_pkg::S_FIND;
                        end
                        pts_pkg::CMD_TICK, pts_pkg::CMD_RESCHED:
                        begin
                            state_next = pts_pkg::S_WALK;
                        end
                        default:
                        begin
                            state_next = pts_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            pts_pkg::S_FIND:
            begin
                if (last)
                begin
                    state_next = (del_found_reg || sout.match) ? pts_pkg::S_DELETE
                                                               : pts_pkg::S_FINISH;
                end
            end
            pts_pkg::S_DELETE:
            begin
                state_next = pts_pkg::S_WALK;
            end
            pts_pkg::S_WALK:
            begin
                if (last)
                begin
                    state_next = pts_pkg::S_FINISH;
                end
            end
            pts_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = pts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pts_pkg::S_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        in_ready      = state_reg == pts_pkg::S_IDLE;
        tbl.ins.id    = thread_id;
        tbl.ins.prio  = priority_req;
        tbl.ins.state = pts_pkg::tstate_t'(thread_state);
        tbl.ins.sleep = sleep_count;
        tbl.upd       = sout.upd;
        tbl.op        = pts_pkg::TBL_HOLD;
        unique case (state_reg) inside
            pts_pkg::S_IDLE:
            begin
                if (accept && command == pts_pkg::CMD_ADD && !full)
                begin
                    tbl.op = pts_pkg::TBL_INSERT;
                end
            end
            pts_pkg::S_FIND, pts_pkg::S_WALK:
            begin
                tbl.op = pts_pkg::TBL_ROTATE;
            end
            pts_pkg::S_DELETE:
            begin
                tbl.op = pts_pkg::TBL_DELETE;
            end
            default:
            begin
                tbl.op = pts_pkg::TBL_HOLD;
            end
        endcase
    end

    assign del_idx = del_idx_reg;

    // datapath
    always_comb
    begin
        cmd_next          = cmd_reg;
        id_next           = id_reg;
        step_next         = step_reg;
        found_next        = found_reg;
        best_next         = best_reg;
        pick_next         = pick_reg;
        acc_min_next      = acc_min_reg;
        del_found_next    = del_found_reg;
        del_idx_next      = del_idx_reg;
        count_next        = count_reg;
        current_next      = current_reg;
        chosen_id_next    = chosen_id_reg;
        chosen_valid_next = chosen_valid_reg;
        min_sleep_next    = min_sleep_reg;
        clock_next        = clock_reg;
        refused_next      = refused_reg;
        res_next          = res_reg;
        res_valid_next    = res_valid_reg && !res_ready;

        unique case (state_reg)
            pts_pkg::S_IDLE:
            begin
                step_next      = '0;
                found_next     = 1'b0;
                best_next      = '0;
                pick_next      = '0;
                acc_min_next   = pts_pkg::NO_SLEEP;
                del_found_next = 1'b0;
                if (accept)
                begin
                    cmd_next     = command;
                    id_next      = thread_id;
                    refused_next = 1'b0;
                    case (pts_pkg::cmd_t'(command))
                        pts_pkg::CMD_ADD:
                        begin
                            if (full)
                            begin
                                refused_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        pts_pkg::CMD_TICK:
                        begin
                            clock_next = clock_reg + 64'd1;
                        end
                        pts_pkg::CMD_COMMIT:
                        begin
                            if (chosen_valid_reg)
                            begin
                                current_next = chosen_id_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            pts_pkg::S_FIND:
            begin
                step_next = step_reg + IDX_W'(1);
                if (sout.match && !del_found_reg)
                begin
                    del_found_next = 1'b1;
                    del_idx_next   = step_reg;
                end
            end
            pts_pkg::S_DELETE:
            begin
                count_next   = count_reg - CNT_W'(1);
                step_next    = '0;
                found_next   = 1'b0;
                best_next    = '0;
                pick_next    = '0;
                acc_min_next = pts_pkg::NO_SLEEP;
            end
            pts_pkg::S_WALK:
            begin
                step_next = step_reg + IDX_W'(1);
                if (sout.take)
                begin
                    found_next = 1'b1;
                    best_next  = sout.upd.prio;
                    pick_next  = sout.upd.id;
                end
                if (sout.lower)
                begin
                    acc_min_next = sout.upd.sleep;
                end
                if (last)
                begin
                    min_sleep_next = (acc_min_next == pts_pkg::NO_SLEEP) ? 32'd0 : acc_min_next;
                    if (pick_cmd)
                    begin
                        chosen_valid_next = found_next;
                        chosen_id_next    = found_next ? pick_next : 8'd0;
                    end
                end
            end
            pts_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next           = 1'b1;
                    res_next.next_id         = chosen_id_reg;
                    res_next.next_valid      = chosen_valid_reg;
                    res_next.switch_needed   = chosen_valid_reg && chosen_id_reg != current_reg;
                    res_next.current_id      = current_reg;
                    res_next.min_sleep_count = min_sleep_reg;
                    res_next.clock_ticks     = clock_reg;
                    res_next.table_full      = refused_reg;
                    res_next.entry_count     = count_ext[pts_pkg::COUNT_OUT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pts_pkg::S_IDLE;
            cmd_reg          <= '0;
            id_reg           <= '0;
            step_reg         <= '0;
            found_reg        <= 1'b0;
            best_reg         <= '0;
            pick_reg         <= '0;
            acc_min_reg      <= pts_pkg::NO_SLEEP;
            del_found_reg    <= 1'b0;
            del_idx_reg      <= '0;
            count_reg        <= CNT_W'(1);
            current_reg      <= '0;
            chosen_id_reg    <= '0;
            chosen_valid_reg <= 1'b0;
            min_sleep_reg    <= '0;
            clock_reg        <= '0;
            refused_reg      <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cmd_reg          <= cmd_next;
            id_reg           <= id_next;
            step_reg         <= step_next;
            found_reg        <= found_next;
            best_reg         <= best_next;
            pick_reg         <= pick_next;
            acc_min_reg      <= acc_min_next;
            del_found_reg    <= del_found_next;
            del_idx_reg      <= del_idx_next;
            count_reg        <= count_next;
            current_reg      <= current_next;
            chosen_id_reg    <= chosen_id_next;
            chosen_valid_reg <= chosen_valid_next;
            min_sleep_reg    <= min_sleep_next;
            clock_reg        <= clock_next;
            refused_reg      <= refused_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hdl/priority_thread_scheduler_top.sv =====
// Fixed-priority preemptive thread scheduler. Commands arrive as beats on
// sched_cmd and each one returns exactly one result beat on sched_res. The
// thread table is a ring of MAX_ENTRIES slots; every scan rotates it once past
// a single step unit that counts down sleepers, tracks the best ready thread
// and the smallest sleep count. Tick, reschedule and an accepted add scan
// once; a remove that finds its id scans twice, with a delete between the
// scans, and one that misses scans once. Commit, a refused add and unused
// command codes go straight to the result without a scan. A new command is
// taken while the previous result is still held in the output register.
module priority_thread_scheduler_top #(
    parameter int MAX_ENTRIES = pts_pkg::MAX_ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    pts_in_if.sink     sched_cmd,
    pts_out_if.source  sched_res
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);

    pts_pkg::entry_t    head;
    pts_pkg::tbl_ctrl_t tbl;
    pts_pkg::result_t   res;
    logic [IDX_W-1:0]   del_idx;

    pts_table #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (tbl),
        .del_idx (del_idx),
        .head    (head)
    );

    pts_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sched_cmd.valid),
        .in_ready     (sched_cmd.ready),
        .command      (sched_cmd.command),
        .thread_id    (sched_cmd.thread_id),
        .priority_req (sched_cmd.priority_req),
        .thread_state (sched_cmd.thread_state),
        .sleep_count  (sched_cmd.sleep_count),
        .res_valid    (sched_res.valid),
        .res_ready    (sched_res.ready),
        .res          (res),
        .head         (head),
        .tbl          (tbl),
        .del_idx      (del_idx)
    );

    assign sched_res.next_id         = res.next_id;
    assign sched_res.next_valid      = res.next_valid;
    assign sched_res.switch_needed   = res.switch_needed;
    assign sched_res.current_id      = res.current_id;
    assign sched_res.min_sleep_count = res.min_sleep_count;
    assign sched_res.clock_ticks     = res.clock_ticks;
    assign sched_res.table_full      = res.table_full;
    assign sched_res.entry_count     = res.entry_count;

endmodule

// ===== tb/priority_thread_scheduler_top_tb.sv =====
module priority_thread_scheduler_top_tb;

    localparam int SLOTS = pts_pkg::MAX_ENTRIES_DEF;
    localparam int N_DIR = 24;
    localparam int N_RAND = 1526;
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    // idle thread chosen, nothing else in the table
    localparam pts_pkg::result_t IDLE_CHOSEN = '{
        next_id: 8'd0, next_valid: 1'b1, switch_needed: 1'b0, current_id: 8'd0,
        min_sleep_count: 32'd0, clock_ticks: 64'd0, table_full: 1'b0,
        entry_count: 4'd1
    };

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  thread_id;
        logic [7:0]  priority_req;
        logic [1:0]  thread_state;
        logic [31:0] sleep_count;
    } cmd_item_t;

    typedef struct packed {
        logic             typed;
        pts_pkg::result_t want;
    } typed_res_t;

    typedef struct packed {
        cmd_item_t  item;
        typed_res_t res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    pts_in_if  cmd_ch ();
    pts_out_if res_ch ();

    priority_thread_scheduler_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sched_cmd (cmd_ch),
        .sched_res (res_ch)
    );

    always #5 clk = ~clk;

    // thread table mirror
    pts_pkg::entry_t slot [SLOTS];
    int unsigned     used;
    logic [7:0]      cur_thread;
    logic [7:0]      pick_id;
    logic            pick_valid;
    logic [63:0]     ticks;

    typed_res_t       typed_q [$];
    pts_pkg::result_t pending_res [$];
    int               errors = 0;
    bit               calm = 1'b0;

    function automatic cmd_item_t mk(input logic [2:0] c, input logic [7:0] id,
                                     input logic [7:0] p, input logic [1:0] s,
                                     input logic [31:0] sl);
        cmd_item_t it;
        it = '{c, id, p, s, sl};
        return it;
    endfunction

    // highest priority ready/running entry, later slots win ties
    function automatic void choose_next();
        logic [7:0] best;
        logic       found;
        int         i;
        best = 8'd0;
        found = 1'b0;
        pick_id = 8'd0;
        for (i = 0; i < used; i++)
        begin
            if (slot[i].state == pts_pkg::TS_READY || slot[i].state == pts_pkg::TS_RUNNING)
            begin
                if (!found || slot[i].prio >= best)
                begin
                    best = slot[i].prio;
                    pick_id = slot[i].id;
                    found = 1'b1;
                end
            end
        end
        pick_valid = found;
    endfunction

    function automatic pts_pkg::result_t sched_apply(input cmd_item_t it);
        pts_pkg::result_t r;
        logic [31:0]      low_sleep;
        logic             refused;
        int               i;
        int               j;
        int               hit;
        refused = 1'b0;
        case (it.command)
            pts_pkg::CMD_ADD:
            begin
                if (used >= SLOTS)
                begin
                    refused = 1'b1;
                end
                else
                begin
                    for (i = used; i > 0; i--)
                        slot[i] = slot[i-1];
                    slot[0] = '{it.thread_id, it.priority_req,
                                pts_pkg::tstate_t'(it.thread_state), it.sleep_count};
                    used++;
                end
            end
            pts_pkg::CMD_REMOVE:
            begin
                hit = -1;
                for (i = 0; i < used; i++)
                    if (hit < 0 && slot[i].id == it.thread_id)
                        hit = i;
                if (hit >= 0)
                begin
                    for (j = hit; j + 1 < used; j++)
                        slot[j] = slot[j+1];
                    slot[used-1] = '0;
                    used--;
                end
            end
            pts_pkg::CMD_TICK:
            begin
                ticks++;
                for (i = 0; i < used; i++)
                begin
                    if (slot[i].state == pts_pkg::TS_SLEEPING)
                    begin
                        if (slot[i].sleep != 32'd0)
                            slot[i].sleep--;
                        if (slot[i].sleep == 32'd0)
                            slot[i].state = pts_pkg::TS_READY;
                    end
                end
                choose_next();
            end
            pts_pkg::CMD_RESCHED:
            begin
                choose_next();
            end
            pts_pkg::CMD_COMMIT:
            begin
                if (pick_valid)
                    cur_thread = pick_id;
            end
            default:
            begin
            end
        endcase
        low_sleep = pts_pkg::NO_SLEEP;
        for (i = 0; i < used; i++)
            if (slot[i].state == pts_pkg::TS_SLEEPING && slot[i].sleep < low_sleep)
                low_sleep = slot[i].sleep;
        r.next_id = pick_id;
        r.next_valid = pick_valid;
        r.switch_needed = pick_valid && (pick_id != cur_thread);
        r.current_id = cur_thread;
        r.min_sleep_count = (low_sleep == pts_pkg::NO_SLEEP) ? 32'd0 : low_sleep;
        r.clock_ticks = ticks;
        r.table_full = refused;
        r.entry_count = used[pts_pkg::COUNT_OUT_W-1:0];
        return r;
    endfunction

    // watches both channels: predicts on command beats, checks result beats
    always @(posedge clk)
    begin : watch
        typed_res_t       tr;
        pts_pkg::result_t want;
        pts_pkg::result_t got;
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                tr = typed_q.pop_front();
                want = sched_apply(cmd_item_t'{cmd_ch.command, cmd_ch.thread_id,
                                               cmd_ch.priority_req, cmd_ch.thread_state,
                                               cmd_ch.sleep_count});
                if (tr.typed)
                    want = tr.want;
                pending_res.push_back(want);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got = '{res_ch.next_id, res_ch.next_valid, res_ch.switch_needed,
                        res_ch.current_id, res_ch.min_sleep_count, res_ch.clock_ticks,
                        res_ch.table_full, res_ch.entry_count};
                if (pending_res.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    want = pending_res.pop_front();
                    if (got.next_id !== want.next_id)
                    begin
                        $error("next_id: expected %0d, got %0d", want.next_id, got.next_id);
                        errors++;
                    end
                    if (got.next_valid !== want.next_valid)
                    begin
                        $error("next_valid: expected %0d, got %0d",
                               want.next_valid, got.next_valid);
                        errors++;
                    end
                    if (got.switch_needed !== want.switch_needed)
                    begin
                        $error("switch_needed: expected %0d, got %0d",
                               want.switch_needed, got.switch_needed);
                        errors++;
                    end
                    if (got.current_id !== want.current_id)
                    begin
                        $error("current_id: expected %0d, got %0d",
                               want.current_id, got.current_id);
                        errors++;
                    end
                    if (got.min_sleep_count !== want.min_sleep_count)
                    begin
                        $error("min_sleep_count: expected %0d, got %0d",
                               want.min_sleep_count, got.min_sleep_count);
                        errors++;
                    end
                    if (got.clock_ticks !== want.clock_ticks)
                    begin
                        $error("clock_ticks: expected %0d, got %0d",
                               want.clock_ticks, got.clock_ticks);
                        errors++;
                    end
                    if (got.table_full !== want.table_full)
                    begin
                        $error("table_full: expected %0d, got %0d",
                               want.table_full, got.table_full);
                        errors++;
                    end
                    if (got.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, got.entry_count);
                        errors++;
                    end
                end
            end
            res_ch.ready <= calm || ($urandom_range(0, 99) >= 6);
        end
    end

    task automatic send_beat(input cmd_item_t it, input typed_res_t tr);
        typed_q.push_back(tr);
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= it.command;
        cmd_ch.thread_id <= it.thread_id;
        cmd_ch.priority_req <= it.priority_req;
        cmd_ch.thread_state <= it.thread_state;
        cmd_ch.sleep_count <= it.sleep_count;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (!calm && $urandom_range(0, 99) < 30)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_res.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        dir_row_t  dir_rows [N_DIR];
        cmd_item_t it;
        int        n;
        int        roll;
        int        calm_from;

        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = pts_pkg::CMD_ADD;
        cmd_ch.thread_id = 8'd0;
        cmd_ch.priority_req = 8'd0;
        cmd_ch.thread_state = pts_pkg::TS_READY;
        cmd_ch.sleep_count = 32'd0;
        res_ch.ready = 1'b0;

        for (n = 0; n < SLOTS; n++)
            slot[n] = '0;
        slot[0].state = pts_pkg::TS_READY;
        used = 1;
        cur_thread = 8'd0;
        pick_id = 8'd0;
        pick_valid = 1'b0;
        ticks = 64'd0;

        dir_rows = '{
            '{mk(pts_pkg::CMD_RESCHED, 8'd0, 8'd0, pts_pkg::TS_READY, 32'd0),
              '{1'b1, IDLE_CHOSEN}},
            '{mk(CMD_SPARE_HI, 8'd0, 8'd0, pts_pkg::TS_READY, 32'd0),
              '{1'b1, IDLE_CHOSEN}},
            '{mk(pts_pkg::CMD_COMMIT, 8'd0, 8'd0, pts_pkg::TS_READY, 32'd0),
              '{1'b1, IDLE_CHOSEN}},
            '{mk(pts_pkg::CMD_ADD, 8'd255, 8'd255, pts_pkg::TS_READY, 32'hFFFF_FFFF), '0},
            // sleeper at the all-ones count reads back as no sleeper
            '{mk(pts_pkg::CMD_ADD, 8'd1, 8'd0, pts_pkg::TS_SLEEPING, 32'hFFFF_FFFF), '0},
            '{mk(pts_pkg::CMD_ADD, 8'd2, 8'd0, pts_pkg::TS_SLEEPING, 32'd0), '0},
            '{mk(pts_pkg::CMD_ADD, 8'd3, 8'd255, pts_pkg::TS_BLOCKED, 32'd3), '0},
            '{mk(pts_pkg::CMD_ADD, 8'd4, 8'd255, pts_pkg::TS_RUNNING, 32'd1), '0},
            '{mk(pts_pkg::CMD_ADD, 8'd2, 8'd7, pts_pkg::TS_SLEEPING, 32'd2), '0},
            '{mk(pts_pkg::CMD_ADD, 8'd5, 8'd128, pts_pkg::TS_READY, 32'd0), '0},
            '{mk(pts_pkg::CMD_ADD, 8'd6, 8'd9, pts_pkg::TS_READY, 32'd0), '0},
            '{mk(pts_pkg::CMD_TICK, 8'd0, 8'd0, pts_pkg::TS_READY, 32'd0), '0},
            '{mk(pts_pkg::CMD_RESCHED, 8'd0, 8'd0, pts_pkg::TS_READY, 32'd0), '0},
            '{mk(pts_pkg::CMD_COMMIT, 8'd0, 8'd0, pts_pkg::TS_READY, 32'd0), '0},
            '{mk(pts_pkg::CMD_REMOVE, 8'd2, 8'd0, pts_pkg::TS_READY, 32'd0), '0},
            '{mk(pts_pkg::CMD_REMOVE, 8'd200, 8'd0, pts_pkg::TS_READY, 32'd0), '0},
            '{mk(pts_pkg::CMD_REMOVE, 8'd0, 8'd0, pts_pkg::TS_READY, 32'd0), '0},
            '{mk(pts_pkg::CMD_REMOVE, 8'd255, 8'd0, pts_pkg::TS_READY, 32'd0), '0},
            '{mk(pts_pkg::CMD_REMOVE, 8'd4, 8'd0, pts_pkg::TS_READY, 32'd0), '0},
            '{mk(pts_pkg::CMD_REMOVE, 8'd5, 8'd0, pts_pkg::TS_READY, 32'd0), '0},
            '{mk(pts_pkg::CMD_REMOVE, 8'd2, 8'd0, pts_pkg::TS_READY, 32'd0), '0},
            '{mk(pts_pkg::CMD_TICK, 8'd0, 8'd0, pts_pkg::TS_READY, 32'd0), '0},
            '{mk(pts_pkg::CMD_COMMIT, 8'd0, 8'd0, pts_pkg::TS_READY, 32'd0), '0},
            '{mk(CMD_SPARE_LO, 8'd0, 8'd0, pts_pkg::TS_READY, 32'd0), '0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < N_DIR; n++)
            send_beat(dir_rows[n].item, dir_rows[n].res);
        drain_results();

        calm_from = $urandom_range(500, 700);
        for (n = 0; n < N_RAND; n++)
        begin
            calm = (n >= calm_from) && (n < calm_from + 250);
            if (n == 400 || n == 1100)
                drain_results();
            it.thread_id = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(0, 11));
            it.priority_req = ($urandom_range(0, 1) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(0, 3));
            it.thread_state = 2'($urandom);
            case ($urandom_range(0, 3))
                0: it.sleep_count = $urandom;
                1: it.sleep_count = pts_pkg::NO_SLEEP - 32'($urandom_range(0, 1));
                default: it.sleep_count = 32'($urandom_range(0, 4));
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 30)
            begin
                it.command = pts_pkg::CMD_ADD;
            end
            else if (roll < 52)
            begin
                it.command = pts_pkg::CMD_REMOVE;
                // mostly hit an id that is in the table
                if (used != 0 && $urandom_range(0, 3) != 0)
                    it.thread_id = slot[$urandom_range(0, used - 1)].id;
            end
            else if (roll < 74)
            begin
                it.command = pts_pkg::CMD_TICK;
            end
            else if (roll < 86)
            begin
                it.command = pts_pkg::CMD_RESCHED;
            end
            else if (roll < 97)
            begin
                it.command = pts_pkg::CMD_COMMIT;
            end
            else
            begin
                it.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            end
            send_beat(it, '0);
        end
        calm = 1'b0;

        drain_results();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
